FILE: rtl/cordsc_pkg.sv
package cordsc_pkg;

   // Step count the tables cover
   localparam int MAX_STEPS = 15;

   // Field widths
   localparam int ANGLE_WIDTH = 20;   // Q8.12 input angle
   localparam int OUT_WIDTH   = 18;   // Q1.16 sine and cosine
   localparam int XY_WIDTH    = 20;   // Q1.16 vector with headroom
   localparam int Z_WIDTH     = 21;   // Q8.12 residual angle with headroom

   localparam int REQ_TDATA_WIDTH = 24;
   localparam int RSP_TDATA_WIDTH = 40;

   typedef logic signed [XY_WIDTH-1:0] xy_type;
   typedef logic signed [Z_WIDTH-1:0]  z_type;

   typedef struct packed {
      xy_type x;
      xy_type y;
      z_type  z;
   } vec_type;

   typedef z_type  atan_table_type [0:MAX_STEPS-1];
   typedef xy_type gain_table_type [0:MAX_STEPS-1];

   // arctan(2^-i) in degrees, Q8.12
   localparam atan_table_type ATAN_DEG_Q12 = '{
      21'sd184320, 21'sd108810, 21'sd57492, 21'sd29184, 21'sd14649,
      21'sd7331,   21'sd3667,   21'sd1833,  21'sd917,   21'sd458,
      21'sd229,    21'sd115,    21'sd57,    21'sd29,    21'sd14
   };

   // 1/K after n micro-rotations (entry n-1), Q1.16
   localparam gain_table_type INV_GAIN_Q16 = '{
      20'sd46341, 20'sd41449, 20'sd40211, 20'sd39901, 20'sd39823,
      20'sd39803, 20'sd39799, 20'sd39797, 20'sd39797, 20'sd39797,
      20'sd39797, 20'sd39797, 20'sd39797, 20'sd39797, 20'sd39797
   };

endpackage

FILE: rtl/cordsc_stage.sv
// One micro-rotation with its pipeline register and local flow control.
module cordsc_stage
   import cordsc_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  vec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output vec_type out_data
);

   logic    valid_ff;
   vec_type data_ff;
   vec_type data_in;
   xy_type  xs;
   xy_type  ys;

   assign xs = in_data.x >>> STEP;
   assign ys = in_data.y >>> STEP;

   // Turn forward while the residual angle is non-negative, back otherwise
   always_comb begin
      if (!in_data.z[Z_WIDTH-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN_DEG_Q12[STEP];
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN_DEG_Q12[STEP];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/cordic_sine_cosine_degrees_unit.sv
// Rotation-mode CORDIC sine and cosine of an angle in degrees. Each req
// transaction carries one signed Q8.12 angle; each rsp transaction returns the
// sine and cosine of that angle in signed Q1.16, in arrival order. The unit is
// a pipeline of ITERATIONS stages, one micro-rotation per stage, so it takes a
// new angle every clock cycle unless back-pressure stalls it; each angle passes
// through the stage registers in order and its result leaves the last stage.
// Every stage has its own valid bit and stalls only when it is full and the
// stage after it is blocked, so bubbles close up under back-pressure and the
// last stage doubles as the output register. Results are meaningful only for
// angles within about +-99 degrees; outside that range the same steps run and
// the outputs are not flagged.
module cordic_sine_cosine_degrees_unit
   import cordsc_pkg::*;
#(
   parameter int ITERATIONS = 15   // micro-rotations, 1 to 15
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,   // [19:0] angle_deg

   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata    // [17:0] sine_value,
                                                   // [35:18] cosine_value
);

   // Stage k drives link k+1; link 0 is the request side
   logic    link_valid [0:ITERATIONS];
   logic    link_ready [0:ITERATIONS];
   vec_type link_data  [0:ITERATIONS];

   // Start vector (1/K, 0) with the angle as residual
   assign link_valid[0] = req_tvalid;
   assign req_tready    = link_ready[0];
   assign link_data[0].x = INV_GAIN_Q16[ITERATIONS-1];
   assign link_data[0].y = '0;
   assign link_data[0].z = z_type'($signed(req_tdata[ANGLE_WIDTH-1:0]));

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
      cordsc_stage #(
         .STEP (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // Last stage holds the result until the consumer takes it
   assign link_ready[ITERATIONS] = rsp_tready;
   assign rsp_tvalid = link_valid[ITERATIONS];
   assign rsp_tdata  = {
      {(RSP_TDATA_WIDTH - 2*OUT_WIDTH){1'b0}},
      link_data[ITERATIONS].x[OUT_WIDTH-1:0],
      link_data[ITERATIONS].y[OUT_WIDTH-1:0]
   };

endmodule

FILE: verif/sincos_result_checker.sv
module sincos_result_checker
   import cordsc_pkg::*;
#(
   parameter int ITERATIONS = 15
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,    // [19:0] angle_deg

   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,    // [17:0] sine_value,
                                                    // [35:18] cosine_value
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [ANGLE_WIDTH-1:0] angle;
      logic [OUT_WIDTH-1:0]          sine;
      logic [OUT_WIDTH-1:0]          cosine;
   } trig_pair_type;

   trig_pair_type sincos_q[$];
   int            errors = 0;
   int            checked = 0;

   // Run the micro-rotations at full int precision; >>> on int floors.
   function automatic trig_pair_type rotate_to_angle(logic signed [ANGLE_WIDTH-1:0] angle);
      trig_pair_type pair;
      int            x, y, z, x_shift, y_shift, steps;
      steps = ITERATIONS < 1 ? 1 : (ITERATIONS > MAX_STEPS ? MAX_STEPS : ITERATIONS);
      z = angle;
      x = INV_GAIN_Q16[steps-1];
      y = 0;
      for (int i = 0; i < steps; i++) begin
         x_shift = x >>> i;
         y_shift = y >>> i;
         if (z >= 0) begin
            x = x - y_shift;
            y = y + x_shift;
            z = z - int'(ATAN_DEG_Q12[i]);
         end else begin
            x = x + y_shift;
            y = y - x_shift;
            z = z + int'(ATAN_DEG_Q12[i]);
         end
      end
      pair.angle  = angle;
      pair.sine   = y[OUT_WIDTH-1:0];
      pair.cosine = x[OUT_WIDTH-1:0];
      return pair;
   endfunction

   always @(posedge clock) begin : watch
      trig_pair_type        want;
      logic [OUT_WIDTH-1:0] got_sine, got_cosine;
      if (reset) begin
         sincos_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            sincos_q.push_back(rotate_to_angle(req_tdata[ANGLE_WIDTH-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got_sine   = rsp_tdata[OUT_WIDTH-1:0];
            got_cosine = rsp_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
            if (sincos_q.size() == 0) begin
               $display("%0t: unexpected result sine %0d cosine %0d", $time,
                        $signed(got_sine), $signed(got_cosine));
               errors++;
            end else begin
               want = sincos_q.pop_front();
               checked++;
               if (got_sine !== want.sine) begin
                  $display("%0t: sine of angle %0d: expected %0d, actual %0d", $time,
                           want.angle, $signed(want.sine), $signed(got_sine));
                  errors++;
               end
               if (got_cosine !== want.cosine) begin
                  $display("%0t: cosine of angle %0d: expected %0d, actual %0d", $time,
                           want.angle, $signed(want.cosine), $signed(got_cosine));
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= sincos_q.size();
      checked_count <= checked;
   end

endmodule

FILE: verif/cordic_sine_cosine_degrees_unit_tb.sv
module cordic_sine_cosine_degrees_unit_tb;
   import cordsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERATIONS     = 15;
   localparam int RANDOM_ITEMS   = 930;
   localparam int BLOCK_ITEMS    = 40;       // items per idling mode
   localparam int MAX_GAP        = 17;
   localparam int WATCHDOG_LIMIT = 2000;     // cycles with no transaction at all
   localparam int DEG            = 4096;     // one degree in Q8.12
   localparam int CONVERGED_MAX  = 99 * DEG; // edge of the useful range

   // Directed angles in Q8.12: zero, one LSB either way, the field extremes,
   // the right angles, 45, 30 and 60 degrees, one degree either way, the half
   // turn, the edge of convergence and just past it, and alternating bit patterns.
   localparam int DIRECTED_ANGLES [20] = '{
      0, 1, -1, 524287, -524288,
      90 * DEG, -90 * DEG, 45 * DEG, -45 * DEG, 30 * DEG,
      60 * DEG, DEG, -DEG, CONVERGED_MAX, -CONVERGED_MAX,
      100 * DEG, 180 * DEG, -180 * DEG, 349525, -349526
   };

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;   // [19:0] angle_deg
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;         // [17:0] sine_value,
                                                  // [35:18] cosine_value
   logic                       rx_steady  = 1'b0; // receiver takes every result at once

   int fail_count, pending_count, checked_count;
   int sent_count     = 0;
   int in_range_count = 0;
   int idle_cycles    = 0;

   always #5ns clock = ~clock;

   cordic_sine_cosine_degrees_unit #(
      .ITERATIONS (ITERATIONS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predict every accepted angle and score every accepted result.
   sincos_result_checker #(
      .ITERATIONS (ITERATIONS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Watchdog: give up once no transaction has moved on either side for
   // far longer than the worst sender gap, receiver stall and pipeline
   // latency put together.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one angle after an idle gap and hold it until the unit takes it.
   // A zero gap keeps tvalid high straight across back-to-back transactions.
   task automatic send_angle(input logic [ANGLE_WIDTH-1:0] angle, input int gap);
      int value;
      value = int'($signed(angle));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_WIDTH-ANGLE_WIDTH){1'b0}}, angle};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (value <= CONVERGED_MAX && value >= -CONVERGED_MAX)
         in_range_count++;
   endtask

   // Drop tvalid and hold off until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Receiver: draw a stall before each result, then take it. In steady
   // stretches keep tready high throughout.
   initial begin : receiver
      int stall;
      @(negedge reset);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      int mode;
      int angle;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed corners with random gaps, then let the pipe empty.
      foreach (DIRECTED_ANGLES[k])
         send_angle(DIRECTED_ANGLES[k][ANGLE_WIDTH-1:0], $urandom_range(0, MAX_GAP));
      drain_results();

      // Random angles: mostly inside the convergence range, the rest any
      // 20-bit pattern. Each block picks whether sender and receiver idle.
      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) begin
            mode = $urandom_range(0, 3);
            rx_steady <= mode[1];
         end
         if (n == RANDOM_ITEMS / 2)
            drain_results();
         if ($urandom_range(0, 9) < 7)
            angle = $urandom_range(0, 2 * CONVERGED_MAX) - CONVERGED_MAX;
         else
            angle = $urandom();
         send_angle(angle[ANGLE_WIDTH-1:0], mode[0] ? 0 : $urandom_range(0, MAX_GAP));
      end

      drain_results();
      repeat (ITERATIONS + 5) @(posedge clock);

      $display("Sent %0d angles (%0d directed, %0d within +-99 degrees) under random gaps",
               sent_count, $size(DIRECTED_ANGLES), in_range_count);
      $display("and stalls; %0d sine/cosine results checked against the predictor",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
